### hw/rtl/tpf_pkg.sv
// Shared types and constants for the transport stream PID filter.
`timescale 1ns / 1ps

package tpf_pkg;

	localparam int MAX_PIDS_DEF = 16;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	localparam logic [1:0] KIND_TABLE = 2'd0;

	localparam logic [1:0] AFC_PAYLOAD = 2'b01;
	localparam logic [1:0] AFC_ADAPT   = 2'b10;
	localparam logic [7:0] PCR_FLAG    = 8'h10;
	localparam logic [3:0] CC_MASK     = 4'hf;

	localparam logic [8:0] HDR_LEN  = 9'd4;
	localparam logic [8:0] PKT_SIZE = 9'd188;

	// Classified header word handed from the front to the back.
	typedef struct packed {
		logic        op;
		logic [12:0] pid;
		logic [1:0]  kind;
		logic [3:0]  cc;
		logic        has_payload;
		logic [8:0]  offset;
		logic [63:0] pcr_hit;
		logic [63:0] pcr_in;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  entry_index;
		logic [1:0]  entry_kind;
		logic        cc_error;
		logic [63:0] pcr_out;
		logic [8:0]  payload_offset;
		logic        section_hold;
		logic        table_full;
		logic [31:0] cc_error_total;
	} res_t;

endpackage

### hw/rtl/tpf_front.sv
// Front end: header classification and a two-word command queue.
`timescale 1ns / 1ps

module tpf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [12:0]         pid,
	input  logic [1:0]          kind,
	input  logic [7:0]          header_byte3,
	input  logic [7:0]          af_length,
	input  logic [7:0]          af_flags,
	input  logic [39:0]         pcr_bytes,
	input  logic                scan_pcr,
	input  logic signed [63:0]  pcr_in,
	output logic                cmd_valid,
	output tpf_pkg::cmd_t       cmd,
	input  logic                cmd_pop
);

	tpf_pkg::cmd_t cmd_in;
	tpf_pkg::cmd_t queue_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic [1:0]    afc;
	logic          has_adapt;
	logic          push;
	logic          pop;

	assign afc       = header_byte3[5:4];
	assign has_adapt = (afc & tpf_pkg::AFC_ADAPT) != 2'b00;

	always_comb begin
		cmd_in.op          = op;
		cmd_in.pid         = pid;
		cmd_in.kind        = kind;
		cmd_in.cc          = header_byte3[3:0] & tpf_pkg::CC_MASK;
		cmd_in.has_payload = (afc & tpf_pkg::AFC_PAYLOAD) != 2'b00;
		// header plus length byte plus the adaptation field itself
		cmd_in.offset      = has_adapt ? (tpf_pkg::HDR_LEN + 9'(af_length) + 9'd1)
		                               : tpf_pkg::HDR_LEN;
		cmd_in.pcr_in      = $unsigned(pcr_in);
		if (has_adapt && scan_pcr && ((af_flags & tpf_pkg::PCR_FLAG) != 8'h00)) begin
			cmd_in.pcr_hit = {31'b0, pcr_bytes[39:7]};
		end else begin
			cmd_in.pcr_hit = $unsigned(pcr_in);
		end
	end

	assign in_stall  = count_q == 2'd2;
	assign push      = in_valid && !in_stall;
	assign cmd_valid = count_q != 2'd0;
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

### hw/rtl/tpf_back.sv
// Back end: PID table walk, continuity check and result register.
`timescale 1ns / 1ps

module tpf_back #(
	parameter int MAX_PIDS = tpf_pkg::MAX_PIDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  tpf_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output tpf_pkg::res_t  res
);

	localparam int IW = (MAX_PIDS > 1) ? $clog2(MAX_PIDS) : 1;
	localparam int CW = $clog2(MAX_PIDS + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t        state_q;
	tpf_pkg::cmd_t cmd_q;
	logic [IW-1:0] cmp_idx_q;
	logic [IW-1:0] hit_idx_q;
	logic [1:0]    hit_kind_q;
	logic [3:0]    hit_ecc_q;
	logic          hit_seen_q;
	logic          hit_q;
	logic [CW-1:0] used_q;
	logic [31:0]   err_cnt_q;
	logic          out_valid_q;
	tpf_pkg::res_t res_q;

	logic [12:0]   pid_mem [MAX_PIDS];
	logic [1:0]    kind_mem [MAX_PIDS];
	logic [3:0]    ecc_mem [MAX_PIDS];
	logic          seen_mem [MAX_PIDS];
	logic [12:0]   rd_pid_q;
	logic [1:0]    rd_kind_q;
	logic [3:0]    rd_ecc_q;
	logic          rd_seen_q;
	logic [IW-1:0] rd_addr;

	logic          match;
	logic          last_cmp;
	logic          out_free;
	logic          finish;
	logic          is_add;
	logic          add_new;
	logic          pkt_hit;
	logic          cc_upd;
	logic          err;
	logic [IW-1:0] wr_addr;
	logic [31:0]   err_cnt_next;
	tpf_pkg::res_t res_d;

	assign match    = rd_pid_q == cmd_q.pid;
	assign last_cmp = ((IW + 1)'(cmp_idx_q) + (IW + 1)'(1)) == (IW + 1)'(used_q);
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == ST_FINISH) && out_free;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;

	// Read the next entry while the current one is compared.
	always_comb begin
		rd_addr = '0;
		if (state_q == ST_SEARCH) begin
			rd_addr = cmp_idx_q + IW'(1);
		end
	end

	always_comb begin
		is_add  = cmd_q.op == tpf_pkg::OP_ADD;
		add_new = is_add && !hit_q && (used_q != CW'(MAX_PIDS));
		pkt_hit = !is_add && hit_q;
		cc_upd  = pkt_hit && cmd_q.has_payload;
		err     = cc_upd && hit_seen_q && (cmd_q.cc != hit_ecc_q);
		wr_addr = add_new ? IW'(used_q) : hit_idx_q;
		err_cnt_next = (err && (err_cnt_q != '1)) ? err_cnt_q + 32'd1 : err_cnt_q;

		res_d.found       = hit_q || add_new;
		res_d.entry_index = hit_q ? 4'(hit_idx_q) : (add_new ? 4'(used_q) : 4'd0);
		res_d.entry_kind  = hit_q ? hit_kind_q : (add_new ? cmd_q.kind : 2'd0);
		res_d.cc_error    = err;
		res_d.payload_offset = pkt_hit ? cmd_q.offset : 9'd0;
		res_d.section_hold   = pkt_hit && (hit_kind_q == tpf_pkg::KIND_TABLE)
		                       && (err || (cmd_q.offset >= tpf_pkg::PKT_SIZE));
		res_d.table_full     = is_add && !hit_q && !add_new;
		res_d.cc_error_total = err_cnt_next;
		if (is_add) begin
			res_d.pcr_out = 64'd0;
		end else if (hit_q) begin
			res_d.pcr_out = cmd_q.pcr_hit;
		end else begin
			res_d.pcr_out = cmd_q.pcr_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hit_q       <= 1'b0;
			cmp_idx_q   <= '0;
			used_q      <= '0;
			err_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						hit_q     <= 1'b0;
						cmp_idx_q <= '0;
						state_q   <= (used_q == '0) ? ST_FINISH : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else if (last_cmp) begin
						state_q <= ST_FINISH;
					end else begin
						cmp_idx_q <= cmp_idx_q + IW'(1);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						err_cnt_q <= err_cnt_next;
						if (add_new) begin
							used_q <= used_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers and table memory.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if ((state_q == ST_SEARCH) && match) begin
			hit_idx_q  <= cmp_idx_q;
			hit_kind_q <= rd_kind_q;
			hit_ecc_q  <= rd_ecc_q;
			hit_seen_q <= rd_seen_q;
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_pid_q  <= pid_mem[rd_addr];
		rd_kind_q <= kind_mem[rd_addr];
		rd_ecc_q  <= ecc_mem[rd_addr];
		rd_seen_q <= seen_mem[rd_addr];
		if (finish && add_new) begin
			pid_mem[wr_addr]  <= cmd_q.pid;
			kind_mem[wr_addr] <= cmd_q.kind;
		end
		// clear the seen mark on a new entry, set it on a payload packet
		if (finish && (add_new || cc_upd)) begin
			ecc_mem[wr_addr]  <= add_new ? 4'd0 : ((cmd_q.cc + 4'd1) & tpf_pkg::CC_MASK);
			seen_mem[wr_addr] <= cc_upd;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

### hw/rtl/ts_pid_filter_cc_pcr.sv
// Top level of the transport stream PID filter with continuity check and PCR pick-up.
`timescale 1ns / 1ps

// Each input word is either a PID registration or one packet header, and each
// gives exactly one result word. Words are classified on entry and wait in a
// two-word queue; the back end then walks the PID table one entry per cycle
// through the single read port of the table memory. After registering a result
// the back end returns to idle and then takes the next queued word. The result
// sits in an output register that may be stalled while the next words are
// queued. No clearing pass is needed after reset: only entries below the fill
// count are ever compared.
module ts_pid_filter_cc_pcr #(
	parameter int MAX_PIDS = tpf_pkg::MAX_PIDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [12:0]        pid,
	input  logic [1:0]         kind,
	input  logic [7:0]         header_byte3,
	input  logic [7:0]         af_length,
	input  logic [7:0]         af_flags,
	input  logic [39:0]        pcr_bytes,
	input  logic               scan_pcr,
	input  logic signed [63:0] pcr_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [3:0]         entry_index,
	output logic [1:0]         entry_kind,
	output logic               cc_error,
	output logic signed [63:0] pcr_out,
	output logic [8:0]         payload_offset,
	output logic               section_hold,
	output logic               table_full,
	output logic [31:0]        cc_error_total
);

	tpf_pkg::cmd_t cmd;
	tpf_pkg::res_t res;
	logic          cmd_valid;
	logic          cmd_pop;

	tpf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.pid          (pid),
		.kind         (kind),
		.header_byte3 (header_byte3),
		.af_length    (af_length),
		.af_flags     (af_flags),
		.pcr_bytes    (pcr_bytes),
		.scan_pcr     (scan_pcr),
		.pcr_in       (pcr_in),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	tpf_back #(
		.MAX_PIDS (MAX_PIDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	assign found          = res.found;
	assign entry_index    = res.entry_index;
	assign entry_kind     = res.entry_kind;
	assign cc_error       = res.cc_error;
	assign pcr_out        = $signed(res.pcr_out);
	assign payload_offset = res.payload_offset;
	assign section_hold   = res.section_hold;
	assign table_full     = res.table_full;
	assign cc_error_total = res.cc_error_total;

endmodule

### hw/rtl/tpf_checker.sv
// Port-level checks for the PID filter, bound to the top level.
`timescale 1ns / 1ps

module tpf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               found,
	input logic [3:0]         entry_index,
	input logic               cc_error,
	input logic signed [63:0] pcr_out,
	input logic [8:0]         payload_offset,
	input logic               section_hold,
	input logic               table_full,
	input logic [31:0]        cc_error_total
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(found) && $stable(entry_index)
			&& $stable(pcr_out) && $stable(payload_offset) && $stable(cc_error_total))
		else $error("result changed while stalled");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(found && table_full))
		else $error("table full on a successful lookup");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> !cc_error && !section_hold
			&& (payload_offset == 9'd0) && (entry_index == 4'd0))
		else $error("miss result carries packet fields");

	a_err_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cc_error |-> (cc_error_total != 32'd0) && found && !table_full)
		else $error("continuity error not counted");

endmodule

bind ts_pid_filter_cc_pcr tpf_checker u_tpf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.found          (found),
	.entry_index    (entry_index),
	.cc_error       (cc_error),
	.pcr_out        (pcr_out),
	.payload_offset (payload_offset),
	.section_hold   (section_hold),
	.table_full     (table_full),
	.cc_error_total (cc_error_total)
);

### test/ts_pid_filter_cc_pcr_tb.sv
// Self-checking testbench for the PID filter with continuity check and PCR pick-up.
`timescale 1ns / 1ps

module ts_pid_filter_cc_pcr_tb;

	localparam int TBL_DEPTH = tpf_pkg::MAX_PIDS_DEF;
	localparam int POOL = 20;
	localparam int N_RANDOM = 1430;

	localparam logic [1:0] KIND_TTX   = 2'd1;
	localparam logic [1:0] KIND_ES    = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] AFC_NONE   = 2'b00;
	localparam logic [1:0] AFC_BOTH   = tpf_pkg::AFC_PAYLOAD | tpf_pkg::AFC_ADAPT;

	typedef struct {
		logic        op;
		logic [12:0] pid;
		logic [1:0]  kind;
		logic [7:0]  b3;
		logic [7:0]  af_len;
		logic [7:0]  af_flg;
		logic [39:0] pcr_b;
		logic        scan;
		logic [63:0] pcr_i;
	} hdr_word_t;

	class pid_filter_scoreboard;
		logic [12:0] tbl_pid[TBL_DEPTH];
		logic [1:0]  tbl_kind[TBL_DEPTH];
		bit          cc_valid[TBL_DEPTH];
		logic [3:0]  cc_next[TBL_DEPTH];
		int          used = 0;
		logic [31:0] err_total = '0;
		tpf_pkg::res_t pending_results[$];
		int          mismatches = 0;

		function tpf_pkg::res_t filter_header(hdr_word_t w);
			tpf_pkg::res_t r;
			int          hit;
			logic [1:0]  afc;
			logic [8:0]  afl;
			logic [63:0] pcr;
			r = '0;
			hit = -1;
			for (int i = 0; i < TBL_DEPTH; i++)
				if (hit < 0 && i < used && tbl_pid[i] == w.pid) hit = i;
			if (w.op == tpf_pkg::OP_ADD) begin
				if (hit < 0 && used < TBL_DEPTH) begin
					hit = used;
					tbl_pid[hit] = w.pid;
					tbl_kind[hit] = w.kind;
					cc_valid[hit] = 1'b0;
					cc_next[hit] = 4'd0;
					used++;
				end
				if (hit >= 0) begin
					r.found = 1'b1;
					r.entry_index = 4'(hit);
					r.entry_kind = tbl_kind[hit];
				end else begin
					r.table_full = 1'b1;
				end
			end else if (hit < 0) begin
				r.pcr_out = w.pcr_i;
			end else begin
				afc = w.b3[5:4];
				afl = 9'd0;
				pcr = w.pcr_i;
				r.found = 1'b1;
				r.entry_index = 4'(hit);
				r.entry_kind = tbl_kind[hit];
				if ((afc & tpf_pkg::AFC_PAYLOAD) != 0) begin
					if (cc_valid[hit] && (w.b3 & tpf_pkg::CC_MASK) != cc_next[hit]) begin
						r.cc_error = 1'b1;
						if (err_total != '1) err_total++;
					end
					cc_valid[hit] = 1'b1;
					cc_next[hit] = w.b3[3:0] + 4'd1;
				end
				if ((afc & tpf_pkg::AFC_ADAPT) != 0) begin
					afl = {1'b0, w.af_len} + 9'd1;
					// PCR base is the top 33 bits of the 40-bit pcr_b field
					if (w.scan && (w.af_flg & tpf_pkg::PCR_FLAG) != 0)
						pcr = {31'd0, w.pcr_b[39:7]};
				end
				r.pcr_out = pcr;
				r.payload_offset = afl + tpf_pkg::HDR_LEN;
				r.section_hold = (tbl_kind[hit] == tpf_pkg::KIND_TABLE) &&
					(r.cc_error || r.payload_offset >= tpf_pkg::PKT_SIZE);
			end
			r.cc_error_total = err_total;
			return r;
		endfunction

		function void note_word(hdr_word_t w);
			pending_results.push_back(filter_header(w));
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
			end
		endfunction

		function void check_result(tpf_pkg::res_t got);
			tpf_pkg::res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("%0t: result word with nothing pending", $realtime);
				return;
			end
			want = pending_results.pop_front();
			cmp_field("found", want.found, got.found);
			cmp_field("entry_index", want.entry_index, got.entry_index);
			cmp_field("entry_kind", want.entry_kind, got.entry_kind);
			cmp_field("cc_error", want.cc_error, got.cc_error);
			cmp_field("pcr_out", want.pcr_out, got.pcr_out);
			cmp_field("payload_offset", want.payload_offset, got.payload_offset);
			cmp_field("section_hold", want.section_hold, got.section_hold);
			cmp_field("table_full", want.table_full, got.table_full);
			cmp_field("cc_error_total", want.cc_error_total, got.cc_error_total);
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               op = 1'b0;
	logic [12:0]        pid = '0;
	logic [1:0]         kind = '0;
	logic [7:0]         header_byte3 = '0;
	logic [7:0]         af_length = '0;
	logic [7:0]         af_flags = '0;
	logic [39:0]        pcr_bytes = '0;
	logic               scan_pcr = 1'b0;
	logic signed [63:0] pcr_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               found;
	logic [3:0]         entry_index;
	logic [1:0]         entry_kind;
	logic               cc_error;
	logic signed [63:0] pcr_out;
	logic [8:0]         payload_offset;
	logic               section_hold;
	logic               table_full;
	logic [31:0]        cc_error_total;

	pid_filter_scoreboard sb;
	int stall_mode = 0;
	int stall_left = 0;

	ts_pid_filter_cc_pcr i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .pid(pid), .kind(kind), .header_byte3(header_byte3),
		.af_length(af_length), .af_flags(af_flags), .pcr_bytes(pcr_bytes),
		.scan_pcr(scan_pcr), .pcr_in(pcr_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .entry_index(entry_index), .entry_kind(entry_kind),
		.cc_error(cc_error), .pcr_out(pcr_out), .payload_offset(payload_offset),
		.section_hold(section_hold), .table_full(table_full),
		.cc_error_total(cc_error_total)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Check the word leaving now, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({found, entry_index, entry_kind, cc_error, pcr_out,
				payload_offset, section_hold, table_full, cc_error_total});
		if (stall_left == 0) begin
			stall_mode = $urandom_range(3);
			stall_left = $urandom_range(5, 60);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(3) == 0);
			2: out_stall <= (stall_left % 9) < 6;
			default: out_stall <= ($urandom_range(9) < 8);
		endcase
	end

	function automatic hdr_word_t make_packet(logic [12:0] p, logic [1:0] afc, logic [3:0] cc,
			logic [7:0] aflen, logic [7:0] flags, logic scan);
		hdr_word_t w;
		w.op = tpf_pkg::OP_PACKET;
		w.pid = p;
		w.kind = 2'($urandom_range(3));
		w.b3 = {2'($urandom_range(3)), afc, cc};
		w.af_len = aflen;
		w.af_flg = flags;
		w.pcr_b = {8'($urandom), 32'($urandom)};
		w.scan = scan;
		w.pcr_i = {32'($urandom), 32'($urandom)};
		return w;
	endfunction

	function automatic hdr_word_t make_add(logic [12:0] p, logic [1:0] k);
		hdr_word_t w;
		w = make_packet(p, 2'($urandom_range(3)), 4'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom));
		w.op = tpf_pkg::OP_ADD;
		w.kind = k;
		return w;
	endfunction

	task automatic send_word(input hdr_word_t w);
		in_valid <= 1'b1;
		op <= w.op;
		pid <= w.pid;
		kind <= w.kind;
		header_byte3 <= w.b3;
		af_length <= w.af_len;
		af_flags <= w.af_flg;
		pcr_bytes <= w.pcr_b;
		scan_pcr <= w.scan;
		pcr_in <= w.pcr_i;
		do @(posedge clk); while (in_stall);
		sb.note_word(w);
	endtask

	// Hold the sender until every pending result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		hdr_word_t   w;
		hdr_word_t   dir_q[$];
		logic [12:0] pool_pid[POOL];
		logic [3:0]  pool_cc[POOL];
		logic [1:0]  afc;
		logic [3:0]  cc;
		logic [7:0]  aflen;
		logic [7:0]  flags;
		int          r;
		int          a;
		int          k;
		int          gap;
		int          burst_left;
		bit          drained;

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table miss, extreme PIDs, every kind, re-add keeps kind
		dir_q.push_back(make_packet(13'd0, AFC_BOTH, 4'd0, 8'd0, tpf_pkg::PCR_FLAG, 1'b1));
		dir_q.push_back(make_add(13'd0, tpf_pkg::KIND_TABLE));
		dir_q.push_back(make_add(13'h1fff, KIND_TTX));
		dir_q.push_back(make_add(13'h0aaa, KIND_ES));
		dir_q.push_back(make_add(13'h1555, KIND_SPARE));
		dir_q.push_back(make_add(13'd0, KIND_ES));
		// counter: first sight, in order, jump on a table stream
		dir_q.push_back(make_packet(13'd0, tpf_pkg::AFC_PAYLOAD, 4'd5, 8'd0, 8'd0, 1'b0));
		dir_q.push_back(make_packet(13'd0, tpf_pkg::AFC_PAYLOAD, 4'd6, 8'd0, 8'd0, 1'b0));
		dir_q.push_back(make_packet(13'd0, tpf_pkg::AFC_PAYLOAD, 4'd9, 8'd0, 8'd0, 1'b0));
		dir_q.push_back(make_packet(13'd0, AFC_BOTH, 4'd10, 8'd0, tpf_pkg::PCR_FLAG, 1'b1));
		// no payload, offset reaches the packet size
		dir_q.push_back(make_packet(13'd0, tpf_pkg::AFC_ADAPT, 4'd3, 8'd183, 8'd0, 1'b1));
		dir_q.push_back(make_packet(13'd0, AFC_NONE, 4'd15, 8'd255, 8'hff, 1'b1));
		w = make_packet(13'h1fff, AFC_BOTH, 4'd15, 8'd255, 8'hff, 1'b0);
		w.pcr_b = '1;
		dir_q.push_back(w);
		dir_q.push_back(make_packet(13'h1fff, AFC_BOTH, 4'd15, 8'd255, 8'hef, 1'b1));
		w = make_packet(13'h0aaa, AFC_BOTH, 4'd15, 8'd7, 8'hff, 1'b1);
		w.pcr_b = '1;
		w.b3[7:6] = 2'b11;
		dir_q.push_back(w);
		w = make_packet(13'h0aaa, tpf_pkg::AFC_PAYLOAD, 4'd0, 8'd0, 8'd0, 1'b0);
		w.b3[7:6] = 2'b00;
		dir_q.push_back(w);
		dir_q.push_back(make_packet(13'h1555, tpf_pkg::AFC_PAYLOAD, 4'd2, 8'd0, 8'd0, 1'b0));
		dir_q.push_back(make_packet(13'h1555, tpf_pkg::AFC_PAYLOAD, 4'd2, 8'd0, 8'd0, 1'b0));
		dir_q.push_back(make_packet(13'h1234, AFC_BOTH, 4'd1, 8'd183, tpf_pkg::PCR_FLAG, 1'b1));
		foreach (dir_q[i]) send_word(dir_q[i]);
		drain();

		pool_pid[0] = 13'd0;
		pool_pid[1] = 13'h1fff;
		pool_pid[2] = 13'h0aaa;
		pool_pid[3] = 13'h1555;
		for (int i = 4; i < POOL; i++) pool_pid[i] = 13'($urandom);
		foreach (pool_cc[i]) pool_cc[i] = 4'($urandom);

		burst_left = 0;
		drained = 1'b0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 12);
				burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
				if (!drained && n >= N_RANDOM / 2) begin
					drained = 1'b1;
					drain();
				end else if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;

			r = $urandom_range(99);
			k = $urandom_range(POOL - 1);
			if (r < 8) begin
				w = make_add(($urandom_range(9) == 0) ? 13'($urandom) : pool_pid[k],
					2'($urandom_range(3)));
			end else if (r < 94) begin
				a = $urandom_range(99);
				afc = (a < 60) ? tpf_pkg::AFC_PAYLOAD : (a < 85) ? AFC_BOTH :
					(a < 95) ? tpf_pkg::AFC_ADAPT : AFC_NONE;
				cc = ($urandom_range(99) < 85) ? pool_cc[k] : 4'($urandom);
				if ((afc & tpf_pkg::AFC_PAYLOAD) != 0) pool_cc[k] = cc + 4'd1;
				a = $urandom_range(9);
				aflen = (a < 8) ? 8'($urandom_range(40)) :
					(a == 8) ? 8'($urandom_range(170, 190)) : 8'($urandom);
				flags = 8'($urandom);
				if ($urandom_range(9) < 6) flags = flags | tpf_pkg::PCR_FLAG;
				w = make_packet(pool_pid[k], afc, cc, aflen, flags, 1'($urandom));
			end else begin
				w = make_packet(13'($urandom), 2'($urandom_range(3)), 4'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
			end
			send_word(w);
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### ts_pid_filter_cc_pcr.f
hw/rtl/tpf_pkg.sv
hw/rtl/tpf_front.sv
hw/rtl/tpf_back.sv
hw/rtl/ts_pid_filter_cc_pcr.sv
hw/rtl/tpf_checker.sv
test/ts_pid_filter_cc_pcr_tb.sv
